FILE: hw/rtl/ecd_pkg.sv
// ----------------------------------------------------------------------------
// ecd_pkg
// Shared types, widths and helpers for the exposure cast detector.
// ----------------------------------------------------------------------------
package ecd_pkg;

   // Histogram geometry
   localparam int HIST_BINS = 256;
   localparam int BIN_W     = 8;
   localparam int CNT_W     = 25;   // per-bin count and pixel count
   localparam int SUM_W     = 32;   // signed offset sum
   localparam int DEV_W     = 34;   // signed N*(i-128) - S
   localparam int ABS_W     = 33;   // magnitude of the deviation
   localparam int ACC_W     = 58;   // weighted deviation sum and |S|*N

   localparam logic [CNT_W-1:0] MAX_PIXELS = CNT_W'(16777216);
   localparam logic [BIN_W-1:0] BIN_LAST   = BIN_W'(HIST_BINS - 1);

   typedef enum logic [1:0] {
      VERDICT_NORMAL = 2'd0,
      VERDICT_BRIGHT = 2'd1,
      VERDICT_DARK   = 2'd2
   } verdict_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_RUN,
      ST_DRAIN,
      ST_WALK,
      ST_FLUSH,
      ST_FINISH
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic pixel_accept;   // take the pixel on the request channel
      logic clear_write;    // write zero to the current bin, advance
      logic walk_start;     // clear the weighted deviation sum
      logic walk_issue;     // read and zero the current bin, advance
      logic finish;         // load result, clear frame totals
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic bin_last;       // bin counter at the final bin
      logic pipe_empty;     // walk pipeline has drained
      logic out_free;       // result register can take a new beat
   } dp_flags_type;

   // Gray level: floor((11r + 16g + 5b) / 32)
   function automatic logic [BIN_W-1:0] to_gray(input logic [7:0] r,
                                                input logic [7:0] g,
                                                input logic [7:0] b);
      logic [12:0] s;
      s = 13'({5'd0, r}) * 13'd11 + {1'b0, g, 4'd0} + 13'({5'd0, b}) * 13'd5;
      return s[12:5];
   endfunction

endpackage

FILE: hw/rtl/ecd_req_if.sv
// ----------------------------------------------------------------------------
// ecd_req_if
// Pixel channel: valid/ready handshake carrying one RGB pixel per beat.
// ----------------------------------------------------------------------------
interface ecd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       last_pixel;

   modport source (output valid, red, green, blue, last_pixel, input ready);
   modport sink   (input valid, red, green, blue, last_pixel, output ready);
endinterface

FILE: hw/rtl/ecd_rsp_if.sv
// ----------------------------------------------------------------------------
// ecd_rsp_if
// Result channel: valid/ready handshake carrying one frame verdict per beat.
// ----------------------------------------------------------------------------
interface ecd_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        verdict;
   logic signed [ecd_pkg::SUM_W-1:0]  offset_sum;
   logic [ecd_pkg::CNT_W-1:0]         pixel_total;

   modport source (output valid, verdict, offset_sum, pixel_total, input ready);
   modport sink   (input valid, verdict, offset_sum, pixel_total, output ready);
endinterface

FILE: hw/rtl/exposure_cast_detector.sv
// ----------------------------------------------------------------------------
// exposure_cast_detector
// Judges a frame of RGB pixels as normally exposed, too bright or too dark.
// ----------------------------------------------------------------------------
// Pixels stream in one per cycle and each is turned into a gray level that
// feeds a 256-bin histogram held in a RAM, a pixel count N and a signed sum S
// of (gray - 128); pixels past 16777216 in a frame are ignored. The pixel
// marked last_pixel closes the frame: the block stops taking pixels while it
// walks the 256 bins, one bin per cycle through the single RAM read port, to
// form M = sum of hist[i] * |N*(i-128) - S| and clears each bin as it goes.
// Once the output register is free it issues one result beat (verdict, S, N)
// from that register and resumes taking pixels while that beat waits. After
// reset a clearing pass zeroes the histogram before the first pixel is taken.
module exposure_cast_detector (
   input  logic      clock,
   input  logic      reset,
   ecd_req_if.sink   req_chan,
   ecd_rsp_if.source rsp_chan
);
   import ecd_pkg::*;

   cmd_type      cmd;
   dp_flags_type status;

   ecd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last_pixel),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ecd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_red   (req_chan.red),
      .req_green (req_chan.green),
      .req_blue  (req_chan.blue),
      .cmd       (cmd),
      .status    (status),
      .rsp_chan  (rsp_chan)
   );
endmodule

FILE: hw/rtl/ecd_ram.sv
// ----------------------------------------------------------------------------
// ecd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ecd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns old data on a same-address write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: hw/rtl/ecd_ctrl.sv
// ----------------------------------------------------------------------------
// ecd_ctrl
// Sequencer: clearing pass, pixel intake, histogram walk and result hand-off.
// ----------------------------------------------------------------------------
module ecd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_last,
   output logic                  req_ready,
   input  ecd_pkg::dp_flags_type status,
   output ecd_pkg::cmd_type      cmd
);
   import ecd_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_write = 1'b1;
            if (status.bin_last) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.pixel_accept = 1'b1;
               if (req_last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            // last pixel's bin update lands this cycle
            cmd.walk_start = 1'b1;
            state_in       = ST_WALK;
         end
         ST_WALK: begin
            cmd.walk_issue = 1'b1;
            if (status.bin_last) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (status.pipe_empty) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_RUN;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end
endmodule

FILE: hw/rtl/ecd_datapath.sv
// ----------------------------------------------------------------------------
// ecd_datapath
// Histogram RAM, frame totals, deviation walk pipeline and result register.
// ----------------------------------------------------------------------------
module ecd_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            req_red,
   input  logic [7:0]            req_green,
   input  logic [7:0]            req_blue,
   input  ecd_pkg::cmd_type      cmd,
   output ecd_pkg::dp_flags_type status,
   ecd_rsp_if.source             rsp_chan
);
   import ecd_pkg::*;

   // Frame totals
   logic [CNT_W-1:0]        count_ff, count_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;

   // Pixel update stage and write forwarding
   logic             s1_valid_ff, s1_valid_in;
   logic [BIN_W-1:0] s1_gray_ff;
   logic             fw_valid_ff;
   logic [BIN_W-1:0] fw_addr_ff;
   logic [CNT_W-1:0] fw_data_ff;

   // Walk pipeline
   logic [BIN_W-1:0]        bin_ff;
   logic                    a_valid_ff, b_valid_ff, c_valid_ff;
   logic signed [DEV_W-1:0] a_off_ff, a_off_in;
   logic [ABS_W-1:0]        b_abs_ff, b_abs_in;
   logic [CNT_W-1:0]        b_hist_ff;
   logic [ACC_W-1:0]        c_prod_ff;
   logic [ACC_W-1:0]        m_ff;
   logic [ACC_W-1:0]        lhs_ff, lhs_in;

   // Result register
   logic                    rsp_valid_ff;
   verdict_type             verdict_ff, verdict_in;
   logic signed [SUM_W-1:0] rsp_sum_ff;
   logic [CNT_W-1:0]        rsp_total_ff;

   // RAM ports
   logic             ram_wr_en;
   logic [BIN_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [CNT_W-1:0] ram_wr_data, ram_rd_data;

   logic [BIN_W-1:0]        gray;
   logic signed [7:0]       gray_rel;
   logic [CNT_W-1:0]        bin_cur;
   logic signed [25:0]      n_s;
   logic signed [7:0]       bin_rel;
   logic signed [DEV_W-1:0] dev;
   logic [SUM_W-1:0]        abs_s;

   ecd_ram #(
      .WIDTH (CNT_W),
      .DEPTH (HIST_BINS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Gray level of the offered pixel, offset from mid-gray
   assign gray     = to_gray(req_red, req_green, req_blue);
   assign gray_rel = {~gray[7], gray[6:0]};

   // Count the pixel unless the frame is already full; finish clears the totals
   always_comb begin
      count_in    = count_ff;
      sum_in      = sum_ff;
      s1_valid_in = 1'b0;
      priority if (cmd.finish) begin
         count_in = '0;
         sum_in   = '0;
      end else if (cmd.pixel_accept && (count_ff < MAX_PIXELS)) begin
         count_in    = count_ff + CNT_W'(1);
         sum_in      = sum_ff + SUM_W'(gray_rel);
         s1_valid_in = 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   // Bin increment with forwarding of the previous cycle's write
   assign bin_cur = (fw_valid_ff && (fw_addr_ff == s1_gray_ff)) ? fw_data_ff : ram_rd_data;

   // RAM port selection
   always_comb begin
      ram_rd_addr = cmd.walk_issue ? bin_ff : gray;
      ram_wr_en   = 1'b0;
      ram_wr_addr = bin_ff;
      ram_wr_data = '0;
      priority if (s1_valid_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = s1_gray_ff;
         ram_wr_data = bin_cur + CNT_W'(1);
      end else if (cmd.clear_write || cmd.walk_issue) begin
         ram_wr_en = 1'b1;
      end else begin
         ram_wr_en = 1'b0;
      end
   end

   // Walk arithmetic: N*(i-128), then |N*(i-128) - S|, then weight by bin
   assign n_s      = $signed({1'b0, count_ff});
   assign bin_rel  = {~bin_ff[7], bin_ff[6:0]};
   assign a_off_in = DEV_W'(n_s) * DEV_W'(bin_rel);
   assign dev      = a_off_ff - DEV_W'(sum_ff);
   assign b_abs_in = dev[DEV_W-1] ? ABS_W'(-dev) : ABS_W'(dev);
   assign abs_s    = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign lhs_in   = ACC_W'(abs_s) * ACC_W'(count_ff);

   // Verdict from S and the two weighted sums
   always_comb begin
      priority if (sum_ff == '0) begin
         verdict_in = VERDICT_NORMAL;
      end else if (lhs_ff >= m_ff) begin
         verdict_in = sum_ff[SUM_W-1] ? VERDICT_DARK : VERDICT_BRIGHT;
      end else begin
         verdict_in = VERDICT_NORMAL;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         sum_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         fw_valid_ff  <= 1'b0;
         bin_ff       <= '0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         sum_ff      <= sum_in;
         s1_valid_ff <= s1_valid_in;
         fw_valid_ff <= s1_valid_ff;
         if (cmd.clear_write || cmd.walk_issue) begin
            bin_ff <= bin_ff + BIN_W'(1);
         end
         a_valid_ff <= cmd.walk_issue;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         // hold the result until the beat is taken
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_gray_ff <= gray;
      fw_addr_ff <= s1_gray_ff;
      fw_data_ff <= ram_wr_data;
      a_off_ff   <= a_off_in;
      b_abs_ff   <= b_abs_in;
      b_hist_ff  <= ram_rd_data;
      c_prod_ff  <= ACC_W'(b_abs_ff) * ACC_W'(b_hist_ff);
      lhs_ff     <= lhs_in;
      if (cmd.walk_start) begin
         m_ff <= '0;
      end else if (c_valid_ff) begin
         m_ff <= m_ff + c_prod_ff;
      end
      if (cmd.finish) begin
         verdict_ff   <= verdict_in;
         rsp_sum_ff   <= sum_ff;
         rsp_total_ff <= count_ff;
      end
   end

   assign status.bin_last   = (bin_ff == BIN_LAST);
   assign status.pipe_empty = !a_valid_ff && !b_valid_ff && !c_valid_ff;
   assign status.out_free   = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.verdict     = verdict_ff;
   assign rsp_chan.offset_sum  = rsp_sum_ff;
   assign rsp_chan.pixel_total = rsp_total_ff;
endmodule

FILE: verif/exposure_cast_detector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exposure_cast_detector_tb
// Streams frames of RGB pixels into the exposure cast detector and checks
// every verdict beat against a cycle-free model of the frame statistics.
// A short table of hand-picked frames runs first, then random frames of
// mostly small sizes with shaped content; both channels idle at random and
// the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module exposure_cast_detector_tb;
   import ecd_pkg::*;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last_pixel;
   } pixel_type;

   typedef struct packed {
      logic [1:0]       verdict;
      logic [SUM_W-1:0] offset_sum;
      logic [CNT_W-1:0] pixel_total;
   } frame_result_type;

   typedef struct {
      pixel_type        pix;
      bit               typed;
      frame_result_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   ecd_req_if req_chan ();
   ecd_rsp_if rsp_chan ();

   exposure_cast_detector dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Clock: 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Frame statistics kept by the checker
   int unsigned      gray_bins [HIST_BINS];
   logic [CNT_W-1:0] frame_pixels;
   longint           frame_offset;

   frame_result_type pending_verdicts [$];
   stim_row_type     directed_rows [$];

   int  mismatch_count = 0;
   int  results_seen   = 0;
   bit  stim_done      = 1'b0;
   bit  sender_calm    = 1'b0;
   bit  receiver_calm  = 1'b0;
   logic hold_off;

   function automatic logic [7:0] gray_level(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
      int weighted;
      weighted = 11 * int'(r) + 16 * int'(g) + 5 * int'(b);
      return 8'(weighted / 32);
   endfunction

   // Judge the frame: |S|*N against sum of hist[i] * |N*(i-128) - S|
   function automatic verdict_type exposure_verdict();
      longint          n;
      longint          s;
      longint          dev;
      longint unsigned spread;
      longint unsigned weight;
      n      = longint'(frame_pixels);
      s      = frame_offset;
      spread = 0;
      if (s == 0) return VERDICT_NORMAL;
      for (int i = 0; i < HIST_BINS; i++) begin
         dev    = n * longint'(i - 128) - s;
         spread += longint'(dev < 0 ? -dev : dev) * longint'(gray_bins[i]);
      end
      weight = longint'(s < 0 ? -s : s) * n;
      if (weight >= spread) return (s > 0) ? VERDICT_BRIGHT : VERDICT_DARK;
      return VERDICT_NORMAL;
   endfunction

   function automatic void clear_frame_stats();
      foreach (gray_bins[i]) gray_bins[i] = 0;
      frame_pixels = '0;
      frame_offset = 0;
   endfunction

   // Fold one accepted pixel into the frame; queue the verdict on a last pixel
   function automatic void absorb_pixel(input stim_row_type row);
      logic [7:0]       gray;
      frame_result_type verdict_beat;
      gray = gray_level(row.pix.red, row.pix.green, row.pix.blue);
      if (frame_pixels < MAX_PIXELS) begin
         gray_bins[gray]++;
         frame_pixels++;
         frame_offset += longint'(gray) - 128;
      end
      if (row.pix.last_pixel) begin
         verdict_beat.verdict     = exposure_verdict();
         verdict_beat.offset_sum  = SUM_W'(frame_offset);
         verdict_beat.pixel_total = frame_pixels;
         pending_verdicts.push_back(row.typed ? row.want : verdict_beat);
         clear_frame_stats();
      end
   endfunction

   function automatic void add_row(input logic [7:0] r, input logic [7:0] g,
                                   input logic [7:0] b, input logic last,
                                   input bit typed = 1'b0,
                                   input verdict_type v = VERDICT_NORMAL,
                                   input int sum = 0, input int total = 0);
      stim_row_type row;
      row.pix              = '{red: r, green: g, blue: b, last_pixel: last};
      row.typed            = typed;
      row.want.verdict     = v;
      row.want.offset_sum  = SUM_W'(sum);
      row.want.pixel_total = CNT_W'(total);
      directed_rows.push_back(row);
   endfunction

   // One channel value around base, clamped to 0..255
   function automatic logic [7:0] near_level(input int base, input int spread);
      int v;
      v = base + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return 8'(v);
   endfunction

   // Offer one pixel beat and hold it until taken
   task automatic send_pixel(input stim_row_type row);
      int gap;
      if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
      gap = sender_calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.red        <= row.pix.red;
      req_chan.green      <= row.pix.green;
      req_chan.blue       <= row.pix.blue;
      req_chan.last_pixel <= row.pix.last_pixel;
      do @(posedge clock); while (!req_chan.ready);
      absorb_pixel(row);
   endtask

   task automatic check_verdict(input frame_result_type got);
      frame_result_type want;
      if (pending_verdicts.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: result beat with no frame pending: verdict %0d sum %0d total %0d",
                     $realtime, got.verdict, $signed(got.offset_sum), got.pixel_total);
         return;
      end
      want = pending_verdicts.pop_front();
      if (got.verdict !== want.verdict || got.offset_sum !== want.offset_sum ||
          got.pixel_total !== want.pixel_total) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: verdict %0d/%0d sum %0d/%0d total %0d/%0d (exp/act)", $realtime,
                     want.verdict, got.verdict, $signed(want.offset_sum),
                     $signed(got.offset_sum), want.pixel_total, got.pixel_total);
      end
   endtask

   // Reset
   initial begin
      reset <= 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // Pixel source: directed table, then random frames
   initial begin : pixel_source
      stim_row_type row;
      int           pixels_sent;
      int           frames_sent;
      int           frame_len;
      int           base;
      int           spread;
      int           pick;
      bit           gray_only;

      req_chan.valid      <= 1'b0;
      req_chan.red        <= '0;
      req_chan.green      <= '0;
      req_chan.blue       <= '0;
      req_chan.last_pixel <= 1'b0;
      clear_frame_stats();

      // single-pixel frames at the extremes
      add_row(8'd255, 8'd255, 8'd255, 1'b1, 1'b1, VERDICT_BRIGHT, 127, 1);
      add_row(8'd0, 8'd0, 8'd0, 1'b1, 1'b1, VERDICT_DARK, -128, 1);
      add_row(8'd128, 8'd128, 8'd128, 1'b1, 1'b1, VERDICT_NORMAL, 0, 1);
      add_row(8'd1, 8'd255, 8'd1, 1'b1, 1'b1, VERDICT_NORMAL, 0, 1);
      add_row(8'd0, 8'd255, 8'd0, 1'b1, 1'b1, VERDICT_DARK, -1, 1);
      add_row(8'd255, 8'd0, 8'd0, 1'b1);
      add_row(8'd0, 8'd0, 8'd255, 1'b1);
      // black and white, nearly balanced
      add_row(8'd0, 8'd0, 8'd0, 1'b0);
      add_row(8'd255, 8'd255, 8'd255, 1'b1);
      // uniform bright frame, zero deviation
      add_row(8'd200, 8'd200, 8'd200, 1'b0);
      add_row(8'd200, 8'd200, 8'd200, 1'b0);
      add_row(8'd200, 8'd200, 8'd200, 1'b1);
      // mixed colors
      add_row(8'd255, 8'd0, 8'd255, 1'b0);
      add_row(8'd0, 8'd255, 8'd0, 1'b0);
      add_row(8'd128, 8'd0, 8'd0, 1'b1);
      // mid frame pulled down by one dark outlier
      add_row(8'd140, 8'd140, 8'd140, 1'b0);
      add_row(8'd140, 8'd140, 8'd140, 1'b0);
      add_row(8'd140, 8'd140, 8'd140, 1'b0);
      add_row(8'd10, 8'd10, 8'd10, 1'b1);

      do @(posedge clock); while (reset);
      foreach (directed_rows[i]) send_pixel(directed_rows[i]);

      // random frames, mostly short, a few long
      pixels_sent = 0;
      frames_sent = 0;
      row.typed   = 1'b0;
      row.want    = '0;
      while (pixels_sent < 500 || frames_sent < 40) begin
         pick = $urandom_range(0, 99);
         if (pick < 80)      frame_len = $urandom_range(1, 6);
         else if (pick < 97) frame_len = $urandom_range(7, 32);
         else                frame_len = $urandom_range(64, 200);
         base = $urandom_range(0, 255);
         case ($urandom_range(0, 3))
            0: spread = 0;
            1: spread = 8;
            2: spread = 40;
            default: spread = 255;
         endcase
         gray_only = $urandom_range(0, 1);
         for (int k = 0; k < frame_len; k++) begin
            row.pix.red        = near_level(base, spread);
            row.pix.green      = gray_only ? row.pix.red : near_level(base, spread);
            row.pix.blue       = gray_only ? row.pix.red : near_level(base, spread);
            row.pix.last_pixel = (k == frame_len - 1);
            send_pixel(row);
         end
         pixels_sent += frame_len;
         frames_sent++;
      end
      req_chan.valid <= 1'b0;
      stim_done = 1'b1;
   end

   // Result sink: random gaps, stalled while the hold-off is on
   initial begin : verdict_sink
      frame_result_type got;
      int               gap;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 39) == 0) receiver_calm = !receiver_calm;
         gap = receiver_calm ? 0 : $urandom_range(0, 3);
         while (hold_off || gap > 0) begin
            rsp_chan.ready <= 1'b0;
            @(posedge clock);
            if (gap > 0) gap--;
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         got.verdict     = rsp_chan.verdict;
         got.offset_sum  = rsp_chan.offset_sum;
         got.pixel_total = rsp_chan.pixel_total;
         check_verdict(got);
         results_seen++;
      end
   end

   // Long hold-off on the result side so the block backs up into the pixel channel
   initial begin : rsp_hold_off
      hold_off <= 1'b0;
      wait (results_seen >= 20);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (3000) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Drain and report
   initial begin : run_control
      wait (stim_done);
      wait (pending_verdicts.size() == 0);
      repeat (400) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("exposure_cast_detector_tb: clean");
      end else begin
         $display("exposure_cast_detector_tb: errors");
      end
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #5_000_000;
      $display("exposure_cast_detector_tb: errors");
      $finish;
   end

endmodule
